/* rtl/tsv_pkg.sv */
// Package for the two-of-three sorted list vote block.
// Holds the shared sizes, codes, sequencer states and the list write beat type.
// Depends on nothing; used by tsv_list_mem and two_of_three_sorted_list_vote.
package tsv_pkg;

  // Entries per list and derived widths.
  localparam int unsigned Depth  = 32;
  localparam int unsigned NLists = 3;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned CntW   = $clog2(Depth + 1);
  localparam int unsigned IdW    = 32;
  localparam int unsigned FoundW = 6;
  localparam int unsigned SelW   = 2;

  // Action codes carried by an input beat.
  localparam logic ActLoad   = 1'b0;
  localparam logic ActFinish = 1'b1;

  // Merge sequencer states.
  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StMin1,
    StMin2,
    StVote,
    StDone
  } state_e;

  // One write into the list storage.
  typedef struct packed {
    logic             en;
    logic [SelW-1:0]  sel;
    logic [AddrW-1:0] addr;
    logic [IdW-1:0]   data;
  } wr_t;

endpackage

/* rtl/tsv_list_mem.sv */
// Storage for the three ID lists: one memory per list.
// One write port shared by all lists, one registered read port per list.
// Depends on tsv_pkg.
module tsv_list_mem (
  input  logic                                               clk_i,
  input  tsv_pkg::wr_t                                       wr_i,
  input  logic [tsv_pkg::NLists-1:0][tsv_pkg::AddrW-1:0]     rd_addr_i,
  output logic [tsv_pkg::NLists-1:0][tsv_pkg::IdW-1:0]       rd_data_o
);

  for (genvar l = 0; l < tsv_pkg::NLists; l++) begin : g_list
    logic [tsv_pkg::IdW-1:0] mem_q [tsv_pkg::Depth];
    logic [tsv_pkg::IdW-1:0] rd_q;

    // Write when the beat targets this list.
    always_ff @(posedge clk_i) begin
      if (wr_i.en && (wr_i.sel == tsv_pkg::SelW'(l))) begin
        mem_q[wr_i.addr] <= wr_i.data;
      end
    end

    // Read port with registered data, valid in the cycle after the address.
    always_ff @(posedge clk_i) begin
      rd_q <= mem_q[rd_addr_i[l]];
    end

    assign rd_data_o[l] = rd_q;
  end

endmodule

/* rtl/two_of_three_sorted_list_vote.sv */
// Top level of the two-of-three sorted list vote block.
// Instantiates tsv_list_mem; uses tsv_pkg for sizes, codes and states.
//
// Usage: the input channel (in_valid_i / in_ready_o) carries one beat per
// item. A load beat (action 0) appends value_i to list list_sel_i; it gives
// no result. A load into a full list is dropped and raises overflow for the
// current job; list_sel_i of 3 is ignored. A finish beat (action 1) starts
// the merge. The input is not ready until the merge is over. Each merge step
// runs through a head read, two passes through the shared 32-bit comparator
// and a vote, and consumes at least one head. The output channel
// (out_valid_o / out_ready_i) delivers every ID found in at least two lists
// in ascending order; the final beat has last_o set, and an empty vote gives
// one beat with none_found_o set. One result is held back so the final beat
// can be marked; when a result is due while the output register is full and
// not taken, the sequencer waits in place.
// After the final beat is queued the counts and overflow clear for the
// next job. Reset clears counts, overflow and the output; the list memory
// needs no clearing since only entries below a list's count are read.
module two_of_three_sorted_list_vote (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       action_i,
  input  logic [tsv_pkg::SelW-1:0]   list_sel_i,
  input  logic [tsv_pkg::IdW-1:0]    value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [tsv_pkg::IdW-1:0]    id_out_o,
  output logic [tsv_pkg::FoundW-1:0] found_so_far_o,
  output logic                       last_o,
  output logic                       none_found_o,
  output logic                       overflow_o
);

  // Control state.
  tsv_pkg::state_e state_q, state_d;
  logic [tsv_pkg::NLists-1:0][tsv_pkg::CntW-1:0] count_q, count_d;
  logic [tsv_pkg::NLists-1:0][tsv_pkg::CntW-1:0] pos_q, pos_d;
  logic dropped_q, dropped_d;
  logic out_v_q, out_v_d;
  logic pend_v_q, pend_v_d;
  logic [tsv_pkg::FoundW-1:0] found_q, found_d;

  // Payload state.
  logic [tsv_pkg::IdW-1:0] mn_q, mn_d;
  logic mn_v_q, mn_v_d;
  logic [tsv_pkg::IdW-1:0] pend_id_q, pend_id_d;
  logic [tsv_pkg::FoundW-1:0] pend_cnt_q, pend_cnt_d;
  logic [tsv_pkg::IdW-1:0] out_id_q, out_id_d;
  logic [tsv_pkg::FoundW-1:0] out_cnt_q, out_cnt_d;
  logic out_last_q, out_last_d;
  logic out_none_q, out_none_d;
  logic out_ovf_q, out_ovf_d;

  // Storage interface.
  tsv_pkg::wr_t wr;
  logic [tsv_pkg::NLists-1:0][tsv_pkg::AddrW-1:0] rd_addr;
  logic [tsv_pkg::NLists-1:0][tsv_pkg::IdW-1:0]   rd_data;

  // Merge helpers.
  logic [tsv_pkg::NLists-1:0] head_v;
  logic [tsv_pkg::NLists-1:0] head_eq;
  logic [1:0]                 votes;
  logic                       hit;
  logic                       push_ok;
  logic                       sel_ok;
  logic [tsv_pkg::IdW-1:0]    cmp_a;
  logic [tsv_pkg::IdW-1:0]    cmp_b;
  logic                       a_lt_b;

  tsv_list_mem u_list_mem (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Heads are always read at the current merge positions.
  always_comb begin
    for (int l = 0; l < tsv_pkg::NLists; l++) begin
      rd_addr[l] = pos_q[l][tsv_pkg::AddrW-1:0];
      head_v[l]  = pos_q[l] < count_q[l];
      head_eq[l] = head_v[l] && (rd_data[l] == mn_q);
    end
  end

  assign votes   = 2'(head_eq[0]) + 2'(head_eq[1]) + 2'(head_eq[2]);
  assign hit     = votes >= 2'd2;
  assign push_ok = !out_v_q || out_ready_i;
  assign sel_ok  = list_sel_i < tsv_pkg::SelW'(tsv_pkg::NLists);

  // Shared magnitude comparator; its operands follow the sequencer state.
  always_comb begin
    cmp_a = rd_data[0];
    cmp_b = rd_data[1];
    case (state_q)
      tsv_pkg::StMin2: begin
        cmp_a = rd_data[2];
        cmp_b = mn_q;
      end
      default: begin
        cmp_a = rd_data[0];
        cmp_b = rd_data[1];
      end
    endcase
  end

  assign a_lt_b = cmp_a < cmp_b;

  // Sequencer: next state, storage writes and datapath updates.
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    pos_d      = pos_q;
    dropped_d  = dropped_q;
    pend_v_d   = pend_v_q;
    found_d    = found_q;
    mn_d       = mn_q;
    mn_v_d     = mn_v_q;
    pend_id_d  = pend_id_q;
    pend_cnt_d = pend_cnt_q;
    out_v_d    = out_v_q && !out_ready_i;
    out_id_d   = out_id_q;
    out_cnt_d  = out_cnt_q;
    out_last_d = out_last_q;
    out_none_d = out_none_q;
    out_ovf_d  = out_ovf_q;
    wr         = '0;
    in_ready_o = 1'b0;

    case (state_q)
      tsv_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (action_i == tsv_pkg::ActFinish) begin
            pos_d    = '0;
            found_d  = '0;
            pend_v_d = 1'b0;
            state_d  = tsv_pkg::StRead;
          end else if (sel_ok) begin
            if (count_q[list_sel_i] < tsv_pkg::CntW'(tsv_pkg::Depth)) begin
              wr.en                = 1'b1;
              wr.sel               = list_sel_i;
              wr.addr              = count_q[list_sel_i][tsv_pkg::AddrW-1:0];
              wr.data              = value_i;
              count_d[list_sel_i]  = count_q[list_sel_i] + tsv_pkg::CntW'(1);
            end else begin
              dropped_d = 1'b1;
            end
          end
        end
      end

      // Head reads are issued here and the data lands in StMin1; stop when every list is used up.
      tsv_pkg::StRead: begin
        if (|head_v) begin
          state_d = tsv_pkg::StMin1;
        end else begin
          state_d = tsv_pkg::StDone;
        end
      end

      // Smaller of the first two heads.
      tsv_pkg::StMin1: begin
        mn_v_d = head_v[0] || head_v[1];
        if (head_v[0] && head_v[1]) begin
          mn_d = a_lt_b ? rd_data[0] : rd_data[1];
        end else if (head_v[0]) begin
          mn_d = rd_data[0];
        end else begin
          mn_d = rd_data[1];
        end
        state_d = tsv_pkg::StMin2;
      end

      // Fold in the third head.
      tsv_pkg::StMin2: begin
        if (head_v[2] && (!mn_v_q || a_lt_b)) begin
          mn_d   = rd_data[2];
          mn_v_d = 1'b1;
        end
        state_d = tsv_pkg::StVote;
      end

      // Advance every head equal to the minimum and record a hit.
      // A hit with a result already held waits until the output is free.
      tsv_pkg::StVote: begin
        if (!(hit && pend_v_q && !push_ok)) begin
          for (int l = 0; l < tsv_pkg::NLists; l++) begin
            if (head_eq[l]) begin
              pos_d[l] = pos_q[l] + tsv_pkg::CntW'(1);
            end
          end
          if (hit) begin
            if (pend_v_q) begin
              out_v_d    = 1'b1;
              out_id_d   = pend_id_q;
              out_cnt_d  = pend_cnt_q;
              out_last_d = 1'b0;
              out_none_d = 1'b0;
              out_ovf_d  = dropped_q;
            end
            pend_v_d   = 1'b1;
            pend_id_d  = mn_q;
            pend_cnt_d = found_q + tsv_pkg::FoundW'(1);
            found_d    = found_q + tsv_pkg::FoundW'(1);
          end
          state_d = tsv_pkg::StRead;
        end
      end

      // Emit the held result as final, or the empty-vote beat, then clear.
      tsv_pkg::StDone: begin
        if (push_ok) begin
          out_v_d    = 1'b1;
          out_id_d   = pend_v_q ? pend_id_q : '0;
          out_cnt_d  = pend_v_q ? pend_cnt_q : '0;
          out_last_d = 1'b1;
          out_none_d = !pend_v_q;
          out_ovf_d  = dropped_q;
          pend_v_d   = 1'b0;
          count_d    = '0;
          pos_d      = '0;
          dropped_d  = 1'b0;
          state_d    = tsv_pkg::StIdle;
        end
      end

      default: begin
        state_d = tsv_pkg::StIdle;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsv_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      pos_q     <= '0;
      dropped_q <= 1'b0;
      out_v_q   <= 1'b0;
      pend_v_q  <= 1'b0;
      found_q   <= '0;
    end else begin
      count_q   <= count_d;
      pos_q     <= pos_d;
      dropped_q <= dropped_d;
      out_v_q   <= out_v_d;
      pend_v_q  <= pend_v_d;
      found_q   <= found_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    mn_q       <= mn_d;
    mn_v_q     <= mn_v_d;
    pend_id_q  <= pend_id_d;
    pend_cnt_q <= pend_cnt_d;
    out_id_q   <= out_id_d;
    out_cnt_q  <= out_cnt_d;
    out_last_q <= out_last_d;
    out_none_q <= out_none_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign out_valid_o    = out_v_q;
  assign id_out_o       = out_id_q;
  assign found_so_far_o = out_cnt_q;
  assign last_o         = out_last_q;
  assign none_found_o   = out_none_q;
  assign overflow_o     = out_ovf_q;

  // The merge never walks past the filled part of a list.
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q[0] <= count_q[0]) && (pos_q[1] <= count_q[1]) && (pos_q[2] <= count_q[2]))
    else $error("merge position beyond list count");

  // A vote step always has a valid minimum from the compare passes.
  a_vote_has_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tsv_pkg::StVote) |-> mn_v_q)
    else $error("vote step without a valid minimum");

  // An empty-vote beat is final and carries a zero total and zero ID.
  a_none_found_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && none_found_o) |-> (last_o && (found_so_far_o == '0) && (id_out_o == '0)))
    else $error("malformed empty-vote beat");

  // Finishing a job leaves the counts and overflow cleared.
  a_job_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == tsv_pkg::StDone) && push_ok) |=> ((count_q == '0) && !dropped_q))
    else $error("job state not cleared after finish");

endmodule
